// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off while reset is low.
`define BPR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check on the rising clock edge that also holds during reset.
`define BPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bpr_pkg.sv =====
package bpr_pkg;

  // Longest search and replacement pattern, in bytes.
  localparam int PATTERN_MAX = 8;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int PAT_W       = 8 * PATTERN_MAX;
  localparam int CNT_W       = 16;
  localparam int CFG_W       = 64;
  localparam int PLEN_RAW_W  = 4;
  localparam int PLEN_RESET  = 8;

  // Token queue between the scanner and the output serializer.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_PATTERN_LEN     = 2'd0,
    CFG_SEARCH_PATTERN  = 2'd1,
    CFG_REPLACE_PATTERN = 2'd2,
    CFG_MAX_REPLACES    = 2'd3
  } cfg_idx_e;

  // Configuration as seen by the datapath, with the pattern length already clamped.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [PAT_W-1:0] spat;
    logic [PAT_W-1:0] rpat;
    logic [CNT_W-1:0] max_rep;
  } cfg_t;

  // One scanner decision: a single literal byte or a whole replacement pattern.
  typedef struct packed {
    logic             repl;
    logic             last;
    logic [7:0]       data;
    logic [CNT_W-1:0] count;
  } token_t;

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic logic [LEN_W-1:0] eff_len(input logic [PLEN_RAW_W-1:0] raw);
    logic [LEN_W-1:0] res;
    if (raw == '0) begin
      res = LEN_W'(1);
    end else if (raw > PLEN_RAW_W'(PATTERN_MAX)) begin
      res = LEN_W'(PATTERN_MAX);
    end else begin
      res = LEN_W'(raw);
    end
    return res;
  endfunction

endpackage

// ===== design/bpr_scan.sv =====
module bpr_scan import bpr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       q_full_i,
  output logic       tok_valid_o,
  output token_t     tok_o
);

  logic [7:0]       win_q [PATTERN_MAX];
  logic [7:0]       win_d [PATTERN_MAX];
  logic [7:0]       win_w [PATTERN_MAX];
  logic [LEN_W-1:0] fill_q, fill_d, fill_w, fill_rest, drop;
  logic [CNT_W-1:0] done_q, done_d, done_inc;
  logic             lastm_q, lastm_d, last_w;
  logic             busy_q, busy_d;
  logic             limited, pending, accept, active;
  logic             search, flush, hit, emit, step_end;

  // Limit check and whether held bytes still need a decision. A step begun by an
  // input transfer runs on while decisions remain; bytes held between steps wait
  // for the next transfer, so they are decided with the settings of that step.
  always_comb begin
    limited    = (cfg_i.max_rep != '0) && (done_q >= cfg_i.max_rep);
    pending    = busy_q &&
                 ((!limited && (fill_q >= cfg_i.len)) ||
                  ((limited || lastm_q) && (fill_q != '0)));
    in_stall_o = pending || q_full_i;
    accept     = in_valid_i && !in_stall_o;
    active     = !q_full_i && (pending || in_valid_i);
  end

  // Working window: the held bytes with a newly accepted byte appended.
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      win_w[i] = (accept && (LEN_W'(i) == fill_q)) ? data_byte_i : win_q[i];
    end
    fill_w = accept ? fill_q + LEN_W'(1) : fill_q;
    last_w = accept ? last_byte_i : lastm_q;
  end

  // Compare the front of the window with the search pattern.
  always_comb begin
    hit = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if ((LEN_W'(i) < cfg_i.len) && (win_w[i] != cfg_i.spat[8*i +: 8])) begin
        hit = 1'b0;
      end
    end
  end

  // One decision per cycle while the queue has room: a match, one literal byte, or just holding.
  always_comb begin
    search    = !limited && (fill_w >= cfg_i.len);
    flush     = (limited || last_w) && (fill_w != '0);
    emit      = active && (search || flush);
    if (!emit) begin
      drop = '0;
    end else if (search && hit) begin
      drop = cfg_i.len;
    end else begin
      drop = LEN_W'(1);
    end
    fill_rest = fill_w - drop;
    step_end  = emit && last_w && (fill_rest == '0);
    done_inc  = (done_q == {CNT_W{1'b1}}) ? done_q : done_q + CNT_W'(1);
  end

  // Next state of the window and the counters.
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (!active) begin
        win_d[i] = win_q[i];
      end else if ((LEN_W'(i) + drop) < LEN_W'(PATTERN_MAX)) begin
        win_d[i] = win_w[IDX_W'(LEN_W'(i) + drop)];
      end else begin
        win_d[i] = '0;
      end
    end
    fill_d  = active ? fill_rest : fill_q;
    lastm_d = active ? (last_w && !step_end) : lastm_q;
    busy_d  = active ? emit : (q_full_i && pending);
    done_d  = done_q;
    if (emit && search && hit) begin
      done_d = done_inc;
    end
    if (step_end) begin
      done_d = '0;
    end
  end

  // Token handed to the output queue.
  always_comb begin
    tok_valid_o = emit;
    tok_o.repl  = search && hit;
    tok_o.last  = step_end;
    tok_o.data  = win_w[0];
    tok_o.count = (search && hit) ? done_inc : done_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      done_q  <= '0;
      lastm_q <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      done_q  <= done_d;
      lastm_q <= lastm_d;
      busy_q  <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      win_q[i] <= win_d[i];
    end
  end

endmodule

// ===== design/bpr_out_queue.sv =====
module bpr_out_queue import bpr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  token_t           tok_i,
  output logic             full_o,
  input  logic [LEN_W-1:0] len_i,
  input  logic [PAT_W-1:0] rpat_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o,
  output logic [CNT_W-1:0] replace_count_o
);

  token_t            q_mem [QDEPTH];
  token_t            head;
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]  idx_q, idx_d, len_m1;
  logic              tail, xfer, pop;

  // Serialize the head token; a replacement spends one transfer per pattern byte.
  always_comb begin
    head            = q_mem[rd_q];
    len_m1          = IDX_W'(len_i - LEN_W'(1));
    tail            = !head.repl || (idx_q == len_m1);
    out_valid_o     = (cnt_q != '0);
    xfer            = out_valid_o && !out_stall_i;
    pop             = xfer && tail;
    full_o          = (cnt_q == (QPTR_W+1)'(QDEPTH));
    out_byte_o      = head.repl ? rpat_i[{idx_q, 3'b000} +: 8] : head.data;
    out_last_o      = head.last && tail;
    replace_count_o = head.count;
  end

  // Occupancy and byte position inside the head token.
  always_comb begin
    cnt_d = cnt_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop);
    idx_d = idx_q;
    if (xfer) begin
      idx_d = tail ? '0 : idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem[wr_q] <= tok_i;
    end
  end

endmodule

// ===== design/byte_pattern_replace.sv =====
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i / in_stall_o data_byte_i, last_byte_i
// output    out        out_valid_o / out_stall_i out_byte_o, out_last_o, replace_count_o
// config    in         cfg_we_i                cfg_idx_i, cfg_data_i
//
// One byte is taken and one byte is delivered per cycle in steady flow; a match
// of n bytes comes out as n replacement bytes, serialized from one queued token.
// The scanner decides one byte or one match per cycle while the queue has room,
// so re-scanning held bytes after a shorter pattern length, or flushing at region
// end or at the limit, stalls the input; a full four-token queue also stalls it.
// Reset clears the window fill, the counters and the token queue.
module byte_pattern_replace import bpr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o,
  output logic [CNT_W-1:0] replace_count_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic [PLEN_RAW_W-1:0] plen_q;
  logic [PAT_W-1:0]      spat_q, rpat_q;
  logic [CNT_W-1:0]      max_q;
  cfg_t                  cfg;
  token_t                tok;
  logic                  tok_valid, q_full;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= PLEN_RAW_W'(PLEN_RESET);
      spat_q <= '0;
      rpat_q <= '0;
      max_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PATTERN_LEN:     plen_q <= cfg_data_i[PLEN_RAW_W-1:0];
        CFG_SEARCH_PATTERN:  spat_q <= cfg_data_i[PAT_W-1:0];
        CFG_REPLACE_PATTERN: rpat_q <= cfg_data_i[PAT_W-1:0];
        CFG_MAX_REPLACES:    max_q  <= cfg_data_i[CNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    cfg.len     = eff_len(plen_q);
    cfg.spat    = spat_q;
    cfg.rpat    = rpat_q;
    cfg.max_rep = max_q;
  end

  bpr_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .tok_valid_o (tok_valid),
    .tok_o       (tok)
  );

  bpr_out_queue u_queue (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (tok_valid),
    .tok_i           (tok),
    .full_o          (q_full),
    .len_i           (cfg.len),
    .rpat_i          (cfg.rpat),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .out_last_o      (out_last_o),
    .replace_count_o (replace_count_o)
  );

endmodule

// ===== design/bpr_checker.sv =====
`include "assert_macros.svh"

module bpr_checker import bpr_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [7:0]       out_byte_o,
  input logic             out_last_o,
  input logic [CNT_W-1:0] replace_count_o
);

  logic             in_xfer, out_xfer;
  logic [6:0]       bal_q;
  logic [CNT_W-1:0] prev_cnt_q;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // Bytes taken but not yet delivered, and the count of the previous delivery.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bal_q      <= '0;
      prev_cnt_q <= '0;
    end else begin
      bal_q <= bal_q + 7'(in_xfer) - 7'(out_xfer);
      if (out_xfer) begin
        prev_cnt_q <= out_last_o ? '0 : replace_count_o;
      end
    end
  end

  // Nothing is offered while reset is held.
  `BPR_ASSERT_ALWAYS(a_quiet_in_reset, clk_i, !rst_ni |-> !out_valid_o,
                     "output valid during reset")

  // Every delivered byte stems from a byte taken earlier.
  `BPR_ASSERT(a_no_invented_byte, clk_i, rst_ni, out_xfer |-> (bal_q != '0),
              "output byte without input")

  // The replacement count never falls inside a region.
  `BPR_ASSERT(a_count_monotonic, clk_i, rst_ni, out_xfer |-> (replace_count_o >= prev_cnt_q),
              "replace count decreased")

  // A stalled result keeps its payload.
  `BPR_ASSERT(a_stall_holds, clk_i, rst_ni,
              out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
              $stable(out_last_o) && $stable(replace_count_o), "stalled output changed")

endmodule

bind byte_pattern_replace bpr_checker u_bpr_checker (.*);

// ===== test/byte_pattern_replace_test.sv =====
`timescale 1ns / 100ps

module byte_pattern_replace_test;
  import bpr_pkg::*;

  // Cycles allowed after the last expected byte for held bytes to be decided.
  localparam int SETTLE_CYCLES = 16;
  localparam int RAND_ITEMS    = 350;
  localparam int RUN_ITEMS     = 64;

  // One output transfer: byte, region end mark and replacement count.
  typedef struct packed {
    logic [7:0]       b;
    logic             lst;
    logic [CNT_W-1:0] cnt;
  } out_rec_t;

  // One row of the directed plan: a register write or an input byte.
  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_e;
  typedef struct {
    row_kind_e   kind;
    cfg_idx_e    idx;
    logic [63:0] val;
    logic [7:0]  b;
    logic        lst;
    bit          typed;
    out_rec_t    want;
  } plan_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [7:0]       data_byte_i;
  logic             last_byte_i;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [7:0]       out_byte_o;
  logic             out_last_o;
  logic [CNT_W-1:0] replace_count_o;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  // Shadow copy of the registers, at their reset values.
  logic [3:0]       plen_raw = 4'd8;
  logic [63:0]      search_bytes = '0;
  logic [63:0]      repl_bytes = '0;
  logic [15:0]      repl_limit = '0;

  // Shadow copy of the scan window and the per-region count.
  logic [7:0]       held_bytes [8];
  int unsigned      held_cnt = 0;
  logic [15:0]      repl_done = '0;

  // Bytes decided by the latest input transfer.
  out_rec_t         step_res [8];
  int unsigned      step_n;

  out_rec_t         pending_out [$];
  plan_row_t        plan [$];
  int unsigned      fail_cnt = 0;
  bit               no_idle = 1'b0;
  logic [7:0]       alphabet [4] = '{8'h00, 8'hFF, 8'hA5, 8'h5A};

  byte_pattern_replace uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .out_last_o      (out_last_o),
    .replace_count_o (replace_count_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Pattern length as the block uses it: zero acts as one, the top is clamped.
  function automatic int unsigned match_len();
    if (plen_raw == 4'd0) return 1;
    if (plen_raw > 4'(PATTERN_MAX)) return PATTERN_MAX;
    return int'(plen_raw);
  endfunction

  function automatic bit limit_hit();
    return repl_limit != 16'd0 && repl_done >= repl_limit;
  endfunction

  function automatic void emit(input logic [7:0] b);
    if (step_n < 8) begin
      step_res[step_n] = '{b: b, lst: 1'b0, cnt: repl_done};
      step_n++;
    end
  endfunction

  function automatic void drop_held(input int unsigned k);
    if (k >= held_cnt) begin
      held_cnt = 0;
    end else begin
      for (int i = 0; i < 8 - k; i++) held_bytes[i] = held_bytes[i + k];
      held_cnt -= k;
    end
  endfunction

  // Takes one input byte into the window and decides every byte it can.
  function automatic void advance_window(input logic [7:0] b, input logic lst);
    int unsigned len;
    bit hit;
    len = match_len();
    step_n = 0;
    if (held_cnt > 7) held_cnt = 7;
    held_bytes[held_cnt] = b;
    held_cnt++;
    while (!limit_hit() && held_cnt >= len) begin
      hit = 1'b1;
      for (int i = 0; i < len; i++) begin
        if (held_bytes[i] != search_bytes[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        if (repl_done != 16'hFFFF) repl_done++;
        for (int i = 0; i < len; i++) emit(repl_bytes[8*i +: 8]);
        drop_held(len);
      end else begin
        emit(held_bytes[0]);
        drop_held(1);
      end
    end
    // Past the limit or at region end, everything held leaves unchanged.
    if (limit_hit() || lst) begin
      for (int i = 0; i < held_cnt; i++) emit(held_bytes[i]);
      held_cnt = 0;
    end
    if (lst) begin
      if (step_n > 0) step_res[step_n - 1].lst = 1'b1;
      for (int i = 0; i < 8; i++) held_bytes[i] = 8'h00;
      held_cnt = 0;
      repl_done = '0;
    end
  endfunction

  function automatic void flag_field(input string fname, input int unsigned want,
                                     input int unsigned got);
    $error("%s: expected %0h, got %0h", fname, want, got);
    fail_cnt++;
  endfunction

  function automatic plan_row_t reg_row(input cfg_idx_e idx, input logic [63:0] val);
    plan_row_t r;
    r = '{kind: ROW_WRITE, idx: idx, val: val, b: 8'h00, lst: 1'b0, typed: 1'b0,
          want: '0};
    return r;
  endfunction

  function automatic plan_row_t byte_row(input logic [7:0] b, input logic lst);
    plan_row_t r;
    r = '{kind: ROW_BYTE, idx: CFG_PATTERN_LEN, val: '0, b: b, lst: lst, typed: 1'b0,
          want: '0};
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic [7:0] b, input logic lst,
                                          input out_rec_t want);
    plan_row_t r;
    r = byte_row(b, lst);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  // Lets the block drain: every expected byte out, then time for held bytes.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] val);
    quiesce();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PATTERN_LEN:     plen_raw = val[3:0];
      CFG_SEARCH_PATTERN:  search_bytes = val;
      CFG_REPLACE_PATTERN: repl_bytes = val;
      CFG_MAX_REPLACES:    repl_limit = val[15:0];
      default: ;
    endcase
  endtask

  // Offers one byte, waits for its transfer and queues the bytes it decides.
  task automatic push_byte(input logic [7:0] b, input logic lst, input bit typed,
                           input out_rec_t want);
    while (!no_idle && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    advance_window(b, lst);
    if (typed) begin
      pending_out.push_back(want);
    end else begin
      for (int i = 0; i < step_n; i++) pending_out.push_back(step_res[i]);
    end
  endtask

  // The receiver stalls at random except during the no-idle stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(99) < 28);
  end

  // Every output transfer is checked against the oldest expected byte.
  always @(posedge clk_i) begin
    out_rec_t exp_rec;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_out.size() == 0) begin
        $error("unexpected transfer: out_byte %0h out_last %0b replace_count %0h",
               out_byte_o, out_last_o, replace_count_o);
        fail_cnt++;
      end else begin
        exp_rec = pending_out.pop_front();
        if (out_byte_o !== exp_rec.b) flag_field("out_byte", exp_rec.b, out_byte_o);
        if (out_last_o !== exp_rec.lst) flag_field("out_last", exp_rec.lst, out_last_o);
        if (replace_count_o !== exp_rec.cnt)
          flag_field("replace_count", exp_rec.cnt, replace_count_o);
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("byte_pattern_replace: mismatch");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned k;
    int unsigned raw;
    int unsigned len;
    int unsigned span;
    int unsigned rlen;
    int unsigned regions;
    logic [63:0] sp;
    logic [15:0] mr;
    logic [7:0]  region_q [$];
    bit          open_end;
    bit          noise;

    for (int i = 0; i < 8; i++) held_bytes[i] = 8'h00;
    rst_ni      = 1'b1;
    in_valid_i  = 1'b0;
    data_byte_i = 8'h00;
    last_byte_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_PATTERN_LEN;
    cfg_data_i  = '0;
    #1;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state: length eight, so single-byte regions flush unchanged.
    plan.push_back(known_row(8'h00, 1'b1, '{8'h00, 1'b1, 16'd0}));
    plan.push_back(known_row(8'hFF, 1'b1, '{8'hFF, 1'b1, 16'd0}));
    // Shortest pattern, all-ones byte replaced by zero.
    plan.push_back(reg_row(CFG_PATTERN_LEN, 64'd1));
    plan.push_back(reg_row(CFG_SEARCH_PATTERN, 64'hFF));
    plan.push_back(reg_row(CFG_REPLACE_PATTERN, 64'h0));
    plan.push_back(known_row(8'hFF, 1'b0, '{8'h00, 1'b0, 16'd1}));
    plan.push_back(known_row(8'h7E, 1'b1, '{8'h7E, 1'b1, 16'd1}));
    // A length of zero acts as one.
    plan.push_back(reg_row(CFG_PATTERN_LEN, 64'd0));
    plan.push_back(reg_row(CFG_SEARCH_PATTERN, 64'h0));
    plan.push_back(reg_row(CFG_REPLACE_PATTERN, 64'hFF));
    plan.push_back(known_row(8'h00, 1'b1, '{8'hFF, 1'b1, 16'd1}));
    // A length above the maximum acts as the maximum; all-ones pattern.
    plan.push_back(reg_row(CFG_PATTERN_LEN, 64'd15));
    plan.push_back(reg_row(CFG_SEARCH_PATTERN, '1));
    plan.push_back(reg_row(CFG_REPLACE_PATTERN, 64'h0));
    for (int i = 0; i < 8; i++) plan.push_back(byte_row(8'hFF, i == 7));
    // Limit lowered while a byte is held: the rest of the region passes.
    plan.push_back(reg_row(CFG_PATTERN_LEN, 64'd2));
    plan.push_back(reg_row(CFG_SEARCH_PATTERN, 64'hCDAB));
    plan.push_back(reg_row(CFG_REPLACE_PATTERN, 64'h3412));
    plan.push_back(reg_row(CFG_MAX_REPLACES, 64'hFFFF));
    plan.push_back(byte_row(8'hAB, 1'b0));
    plan.push_back(byte_row(8'hCD, 1'b0));
    plan.push_back(byte_row(8'hAB, 1'b0));
    plan.push_back(reg_row(CFG_MAX_REPLACES, 64'd1));
    plan.push_back(byte_row(8'hCD, 1'b0));
    plan.push_back(byte_row(8'h55, 1'b1));
    // Length shrunk with bytes held: they are scanned again at the new length.
    plan.push_back(reg_row(CFG_PATTERN_LEN, 64'd4));
    plan.push_back(reg_row(CFG_SEARCH_PATTERN, 64'h44332211));
    plan.push_back(reg_row(CFG_MAX_REPLACES, 64'd0));
    plan.push_back(byte_row(8'h11, 1'b0));
    plan.push_back(byte_row(8'h22, 1'b0));
    plan.push_back(byte_row(8'h33, 1'b0));
    plan.push_back(reg_row(CFG_PATTERN_LEN, 64'd1));
    plan.push_back(byte_row(8'h22, 1'b1));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) write_reg(plan[i].idx, plan[i].val);
      else push_byte(plan[i].b, plan[i].lst, plan[i].typed, plan[i].want);
    end

    // Random phases: new settings, then regions rich in whole and partial matches.
    sent = 0;
    while (sent < RAND_ITEMS) begin
      k = $urandom_range(9);
      raw = (k == 0) ? 0 : (k == 1) ? $urandom_range(15, 9) : $urandom_range(8, 1);
      write_reg(CFG_PATTERN_LEN, 64'(raw));
      if ($urandom_range(1) == 1) begin
        sp = {$urandom, $urandom};
      end else begin
        for (int i = 0; i < 8; i++) sp[8*i +: 8] = alphabet[$urandom_range(3)];
      end
      write_reg(CFG_SEARCH_PATTERN, sp);
      write_reg(CFG_REPLACE_PATTERN, {$urandom, $urandom});
      k = $urandom_range(19);
      mr = (k < 12) ? 16'd0 : (k < 18) ? 16'($urandom_range(3, 1)) :
           (k == 18) ? 16'hFFFF : 16'($urandom_range(65535));
      write_reg(CFG_MAX_REPLACES, 64'(mr));
      len = match_len();
      regions = $urandom_range(4, 1);
      for (int r = 0; r < regions; r++) begin
        rlen = ($urandom_range(9) == 0) ? $urandom_range(48, 25) : $urandom_range(24, 1);
        // Some phases end with the region still open, so held bytes meet new settings.
        open_end = (r == regions - 1) && ($urandom_range(3) == 0);
        noise = ($urandom_range(4) == 0);
        region_q.delete();
        while (region_q.size() < rlen) begin
          k = $urandom_range(9);
          if (!noise && k < 6) begin
            span = (k < 4) ? len : $urandom_range(len, 1);
            for (int j = 0; j < span; j++) region_q.push_back(search_bytes[8*j +: 8]);
          end else if (k < 8) begin
            region_q.push_back(alphabet[$urandom_range(3)]);
          end else begin
            region_q.push_back(8'($urandom));
          end
        end
        foreach (region_q[j])
          push_byte(region_q[j], !open_end && (j == region_q.size() - 1), 1'b0, '0);
        sent += region_q.size();
      end
    end

    // One long region of single-byte matches with no idling on either side.
    write_reg(CFG_PATTERN_LEN, 64'd1);
    write_reg(CFG_SEARCH_PATTERN, 64'h5A);
    write_reg(CFG_REPLACE_PATTERN, {$urandom, $urandom});
    write_reg(CFG_MAX_REPLACES, 64'd0);
    no_idle = 1'b1;
    for (int i = 0; i < RUN_ITEMS; i++) push_byte(8'h5A, i == RUN_ITEMS - 1, 1'b0, '0);
    no_idle = 1'b0;

    quiesce();
    if (fail_cnt == 0) begin
      $display("byte_pattern_replace: match");
    end else begin
      $display("byte_pattern_replace: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/bpr_pkg.sv
design/bpr_scan.sv
design/bpr_out_queue.sv
design/byte_pattern_replace.sv
design/bpr_checker.sv
test/byte_pattern_replace_test.sv
